// File: rtl/tlb_lru_translate_macros.svh
// Assertion macros for the TLB translate RTL.
// Included by tlbt_dp, which checks its own logic; depends on nothing else.
`ifndef TLB_LRU_TRANSLATE_MACROS_SVH
`define TLB_LRU_TRANSLATE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TLBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define TLBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tlbt_pkg.sv
// Shared types and constants of the TLB translate block.
// Used by the controller, the datapath and the top level; depends on nothing.
package tlbt_pkg;

  // Fixed field widths of the stream beats and the configuration registers.
  localparam int VA_W      = 32;
  localparam int PAGE_NB_W = 10;
  localparam int FRAME_NB_W = 20;
  localparam int CNT_W     = 32;
  localparam int OFF_W     = 5;
  localparam int ENT_W     = 5;

  // Configuration register indexes and reset values.
  localparam logic REG_PAGE_OFFSET = 1'b0;
  localparam logic REG_TLB_ENTRIES = 1'b1;
  localparam logic [OFF_W-1:0] PAGE_OFFSET_RST = 5'd12;
  localparam logic [ENT_W-1:0] TLB_ENTRIES_RST = 5'd16;

  // Input kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WORK  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // clear one page table entry
    logic capture;    // take the input beat, start the table read
    logic commit;     // finish the item, update state, load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

// File: rtl/tlbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the page table store.
module tlbt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tlbt_ctrl.sv
// Controller state machine of the TLB translate block.
// Depends on tlbt_pkg for the state, command and status types.
module tlbt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  tlbt_pkg::sts_t sts,
  output tlbt_pkg::cmd_t cmd
);

  tlbt_pkg::state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      tlbt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = tlbt_pkg::ST_IDLE;
        end
      end
      tlbt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = tlbt_pkg::ST_WORK;
        end
      end
      tlbt_pkg::ST_WORK: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = tlbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlbt_pkg::ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/tlbt_dp.sv
// Datapath of the TLB translate block: TLB lanes, page table, totals, output register.
// Depends on tlbt_pkg, tlbt_ram and the assertion macro header.
`include "tlb_lru_translate_macros.svh"

module tlbt_dp #(
  parameter int TLB_MAX         = 16,
  parameter int PAGE_TABLE_BITS = 10,
  parameter int FRAME_BITS      = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlbt_pkg::cmd_t                     cmd,
  output tlbt_pkg::sts_t                     sts,
  // Input fields
  input  logic                               in_mode,
  input  logic [tlbt_pkg::PAGE_NB_W-1:0]     in_page_number,
  input  logic [tlbt_pkg::FRAME_NB_W-1:0]    in_frame_number,
  input  logic [tlbt_pkg::VA_W-1:0]          in_virtual_address,
  // Configuration
  input  logic [tlbt_pkg::OFF_W-1:0]         cfg_off,
  input  logic [tlbt_pkg::ENT_W-1:0]         cfg_entries,
  // Result
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tlbt_pkg::VA_W-1:0]          out_physical_address,
  output logic                               out_hit,
  output logic                               out_unmapped,
  output logic [tlbt_pkg::CNT_W-1:0]         out_hit_total,
  output logic [tlbt_pkg::CNT_W-1:0]         out_miss_total
);

  localparam int TIDX_W = $clog2(TLB_MAX + 1);
  localparam int WORD_W = FRAME_BITS + 1;
  localparam int VA_W   = tlbt_pkg::VA_W;

  // Captured item.
  logic                            mode_r;
  logic [tlbt_pkg::PAGE_NB_W-1:0]  page_nb_r;
  logic [tlbt_pkg::FRAME_NB_W-1:0] frame_nb_r;
  logic [VA_W-1:0]                 va_r;

  // TLB lanes, least recent first.
  logic [VA_W-1:0]       tag_r   [TLB_MAX];
  logic [FRAME_BITS-1:0] frame_r [TLB_MAX];
  logic [TIDX_W-1:0]     fill_r;

  // Totals, clear pass counter and output register.
  logic [tlbt_pkg::CNT_W-1:0]   hits_r, misses_r, hits_nxt, misses_nxt;
  logic [PAGE_TABLE_BITS-1:0]   clr_cnt_r;
  logic                         out_valid_r;
  logic [VA_W-1:0]              phys_r;
  logic                         hit_r, unm_r;

  // Page table port signals.
  logic                       pt_we;
  logic [PAGE_TABLE_BITS-1:0] pt_waddr;
  logic [WORD_W-1:0]          pt_wdata;
  logic [WORD_W-1:0]          pt_rdata;
  logic [VA_W-1:0]            in_page;

  // Lookup signals.
  logic [VA_W-1:0]       page, offset, phys;
  logic [TLB_MAX-1:0]    match, at_or_above;
  logic                  hit, full, shift_mode, access, in_table, mapped;
  logic [FRAME_BITS-1:0] hit_frame, frame;
  logic [TIDX_W-1:0]     cap, w_idx;
  logic [VA_W-1:0]       ld_page;
  logic                  ld_in_range;

  // Page table read address comes straight from the input beat.
  assign in_page = in_virtual_address >> cfg_off;

  // Page table writes: clearing pass, then load items.
  assign ld_page     = VA_W'(page_nb_r);
  assign ld_in_range = (ld_page >> PAGE_TABLE_BITS) == '0;
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = clr_cnt_r;
    pt_wdata = '0;
    if (cmd.clr_step) begin
      pt_we = 1'b1;
    end else if (cmd.commit && (mode_r == tlbt_pkg::MODE_LOAD) && ld_in_range) begin
      pt_we    = 1'b1;
      pt_waddr = ld_page[PAGE_TABLE_BITS-1:0];
      pt_wdata = {1'b1, FRAME_BITS'(frame_nb_r)};
    end
  end

  tlbt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << PAGE_TABLE_BITS)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (cmd.capture),
    .raddr (in_page[PAGE_TABLE_BITS-1:0]),
    .rdata (pt_rdata)
  );

  // Address split of the captured access.
  assign page   = va_r >> cfg_off;
  assign offset = va_r & ~({VA_W{1'b1}} << cfg_off);
  assign access = (mode_r == tlbt_pkg::MODE_ACCESS);

  // Parallel tag compare over the filled lanes; tags are unique.
  always_comb begin
    hit_frame = '0;
    for (int j = 0; j < TLB_MAX; j++) begin
      match[j] = (TIDX_W'(j) < fill_r) && (tag_r[j] == page);
      if (match[j]) begin
        hit_frame = hit_frame | frame_r[j];
      end
    end
    at_or_above[0] = match[0];
    for (int j = 1; j < TLB_MAX; j++) begin
      at_or_above[j] = at_or_above[j-1] | match[j];
    end
  end
  assign hit = |match;

  // Miss path: frame from the page table, or frame 0 when unmapped.
  assign in_table = (page >> PAGE_TABLE_BITS) == '0;
  assign mapped   = in_table && pt_rdata[FRAME_BITS];
  assign frame    = hit ? hit_frame : (mapped ? pt_rdata[FRAME_BITS-1:0] : '0);
  assign phys     = (VA_W'(frame) << cfg_off) | offset;

  // Capacity clamped to one through the built lane count.
  always_comb begin
    if (cfg_entries == '0) begin
      cap = TIDX_W'(1);
    end else if (32'(cfg_entries) > TLB_MAX) begin
      cap = TIDX_W'(TLB_MAX);
    end else begin
      cap = TIDX_W'(cfg_entries);
    end
  end
  assign full       = fill_r >= cap;
  assign shift_mode = hit || full;
  assign w_idx      = shift_mode ? fill_r - TIDX_W'(1) : fill_r;

  // Lane update: shift toward the least recent end, new entry at w_idx.
  for (genvar j = 0; j < TLB_MAX; j++) begin : g_lane
    logic take_next;
    if (j < TLB_MAX - 1) begin : g_shift
      assign take_next = shift_mode && (hit ? at_or_above[j] : 1'b1)
                         && (TIDX_W'(j) < w_idx);
    end else begin : g_end
      assign take_next = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && access) begin
        if (TIDX_W'(j) == w_idx) begin
          tag_r[j]   <= page;
          frame_r[j] <= frame;
        end else if (take_next) begin
          tag_r[j]   <= tag_r[(j + 1) % TLB_MAX];
          frame_r[j] <= frame_r[(j + 1) % TLB_MAX];
        end
      end
    end
  end

  // Saturating totals.
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (access) begin
      if (hit) begin
        hits_nxt = (hits_r == '1) ? hits_r : hits_r + 1'b1;
      end else begin
        misses_nxt = (misses_r == '1) ? misses_r : misses_r + 1'b1;
      end
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= in_mode;
      page_nb_r  <= in_page_number;
      frame_nb_r <= in_frame_number;
      va_r       <= in_virtual_address;
    end
  end

  // Control state: fill count, totals, clear counter, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        out_valid_r <= 1'b1;
        if (access && !shift_mode) begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      phys_r <= access ? phys : '0;
      hit_r  <= access && hit;
      unm_r  <= access && !hit && !mapped;
    end
  end

  assign sts.clr_last = (clr_cnt_r == '1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_physical_address = phys_r;
  assign out_hit              = hit_r;
  assign out_unmapped         = unm_r;
  assign out_hit_total        = hits_r;
  assign out_miss_total       = misses_r;

  // Checks on the lane state and the result hand-off.
  `TLBT_ASSERT_NOW(a_fill_max, clk, rst_n, 1'b1, fill_r <= TIDX_W'(TLB_MAX), "fill count above lane count")
  `TLBT_ASSERT_NOW(a_tag_unique, clk, rst_n, 1'b1, $onehot0(match), "more than one TLB lane matched")
  `TLBT_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, sts.out_free, "result committed over a pending beat")
  `TLBT_ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_r, "committed result not presented")

endmodule

// File: rtl/tlb_lru_translate.sv
// Top level of the fully associative TLB with LRU replacement.
// Depends on tlbt_pkg, tlbt_ctrl, tlbt_dp (with tlbt_ram inside).
//
//   Channel  Ports         Beat contents
//   in       in_t*         tuser: mode; tdata: page_number, frame_number, virtual_address
//   out      out_t*        tuser: hit, unmapped; tdata: physical_address, hit_total, miss_total
//   cfg      cfg_p*        APB writes/reads of page_offset_bits (0x0), tlb_entries_in_use (0x4)
//
// Each item is accepted in the IDLE state, which starts the page table read, and is then
// finished in the WORK state with tag compare, LRU update and result registration.
// After reset the page table valid bits are cleared in a pass over all
// 2**PAGE_TABLE_BITS entries (1024 by default) during which in_tready is low.
// A stalled output holds the finished item in the WORK state; one item may be
// accepted while the previous result waits in the output register.
module tlb_lru_translate #(
  parameter int TLB_MAX         = 16,
  parameter int PAGE_TABLE_BITS = 10,
  parameter int FRAME_BITS      = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [9:0] page_number, [29:10] frame_number,
                                   // [61:30] virtual_address, [63:62] zero
  input  logic        in_tuser,    // [0] mode
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // [31:0] physical_address, [63:32] hit_total,
                                   // [95:64] miss_total
  output logic [1:0]  out_tuser,   // [0] hit, [1] unmapped
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tlbt_pkg::cmd_t cmd;
  tlbt_pkg::sts_t sts;

  logic [tlbt_pkg::OFF_W-1:0] page_offset_bits_r;
  logic [tlbt_pkg::ENT_W-1:0] tlb_entries_in_use_r;
  logic                       cfg_wr;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_offset_bits_r   <= tlbt_pkg::PAGE_OFFSET_RST;
      tlb_entries_in_use_r <= tlbt_pkg::TLB_ENTRIES_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        tlbt_pkg::REG_PAGE_OFFSET: page_offset_bits_r   <= cfg_pwdata[tlbt_pkg::OFF_W-1:0];
        tlbt_pkg::REG_TLB_ENTRIES: tlb_entries_in_use_r <= cfg_pwdata[tlbt_pkg::ENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[2])
      tlbt_pkg::REG_PAGE_OFFSET: cfg_prdata = 32'(page_offset_bits_r);
      tlbt_pkg::REG_TLB_ENTRIES: cfg_prdata = 32'(tlb_entries_in_use_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  tlbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbt_dp #(
    .TLB_MAX         (TLB_MAX),
    .PAGE_TABLE_BITS (PAGE_TABLE_BITS),
    .FRAME_BITS      (FRAME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_tuser),
    .in_page_number       (in_tdata[9:0]),
    .in_frame_number      (in_tdata[29:10]),
    .in_virtual_address   (in_tdata[61:30]),
    .cfg_off              (page_offset_bits_r),
    .cfg_entries          (tlb_entries_in_use_r),
    .out_ready            (out_tready),
    .out_valid            (out_tvalid),
    .out_physical_address (out_tdata[31:0]),
    .out_hit              (out_tuser[0]),
    .out_unmapped         (out_tuser[1]),
    .out_hit_total        (out_tdata[63:32]),
    .out_miss_total       (out_tdata[95:64])
  );

endmodule

// File: verif/tlbt_xlat_checker.sv
// Scoreboard for the TLB translate block: watches the input, result and register ports,
// predicts every result beat and compares it field by field. Depends on tlbt_pkg.
module tlbt_xlat_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [63:0]       in_tdata,    // [9:0] page_number, [29:10] frame_number,
                                         // [61:30] virtual_address, [63:62] zero
  input  logic              in_tuser,    // [0] mode
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [95:0]       out_tdata,   // [31:0] physical_address, [63:32] hit_total,
                                         // [95:64] miss_total
  input  logic [1:0]        out_tuser,   // [0] hit, [1] unmapped
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LRU_DEPTH  = 16;
  localparam int TABLE_SIZE = 1024;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        hit;
    logic        unmapped;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } xlat_result_t;

  // Shadow copy of the block's registers and state.
  logic [tlbt_pkg::OFF_W-1:0] offset_bits;
  logic [tlbt_pkg::ENT_W-1:0] entries_in_use;
  logic [31:0]       lru_tag   [LRU_DEPTH];
  logic [19:0]       lru_frame [LRU_DEPTH];
  int                lru_fill;
  logic [19:0]       pt_frame  [TABLE_SIZE];
  logic              pt_valid  [TABLE_SIZE];
  logic [31:0]       hit_count;
  logic [31:0]       miss_count;

  xlat_result_t expected_xlat[$];
  xlat_result_t want;
  xlat_result_t got;
  int unsigned  fails = 0;

  assign mismatches = fails;

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endtask

  // Drop entry idx from the recency order and place (tag, frame) as most recent.
  function automatic void promote_entry(input int idx, input int last,
                                        input logic [31:0] tag, input logic [19:0] frame);
    for (int j = idx + 1; j <= last; j++) begin
      lru_tag[j-1]   = lru_tag[j];
      lru_frame[j-1] = lru_frame[j];
    end
    lru_tag[last]   = tag;
    lru_frame[last] = frame;
  endfunction

  // Work out the result of one input beat and advance the shadow state.
  function automatic xlat_result_t translate_beat(input logic mode, input logic [9:0] pg,
                                                  input logic [19:0] fr,
                                                  input logic [31:0] va);
    xlat_result_t res;
    int           found;
    int           cap;
    logic [31:0]  page;
    logic [31:0]  offs;
    logic [19:0]  frame;
    logic [63:0]  wide;
    res = '0;
    if (mode == tlbt_pkg::MODE_LOAD) begin
      pt_frame[pg] = fr;
      pt_valid[pg] = 1'b1;
    end else begin
      page  = va >> offset_bits;
      offs  = va & 32'((64'd1 << offset_bits) - 64'd1);
      frame = '0;
      found = -1;
      for (int j = 0; j < lru_fill; j++) begin
        if (found < 0 && lru_tag[j] == page) found = j;
      end
      if (found >= 0) begin
        res.hit = 1'b1;
        frame   = lru_frame[found];
        promote_entry(found, lru_fill - 1, page, frame);
        if (hit_count != 32'hFFFF_FFFF) hit_count++;
      end else begin
        if (page < TABLE_SIZE && pt_valid[page[9:0]]) frame = pt_frame[page[9:0]];
        else res.unmapped = 1'b1;
        // Capacity register outside 1..16 is clamped.
        cap = (entries_in_use == 0) ? 1 :
              (entries_in_use > LRU_DEPTH) ? LRU_DEPTH : int'(entries_in_use);
        if (lru_fill < cap) begin
          lru_tag[lru_fill]   = page;
          lru_frame[lru_fill] = frame;
          lru_fill++;
        end else begin
          promote_entry(0, lru_fill - 1, page, frame);
        end
        if (miss_count != 32'hFFFF_FFFF) miss_count++;
      end
      wide          = (64'(frame) << offset_bits) + 64'(offs);
      res.phys_addr = wide[31:0];
    end
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      offset_bits    = tlbt_pkg::PAGE_OFFSET_RST;
      entries_in_use = tlbt_pkg::TLB_ENTRIES_RST;
      lru_fill       = 0;
      hit_count      = '0;
      miss_count     = '0;
      for (int k = 0; k < TABLE_SIZE; k++) pt_valid[k] = 1'b0;
      expected_xlat.delete();
      outstanding <= 0;
    end else begin
      // Result beat: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tuser[0], out_tuser[1], out_tdata[63:32],
               out_tdata[95:64]};
        if (expected_xlat.size() == 0) begin
          fails++;
          $display("%0t ns: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_xlat.pop_front();
          check_field("physical_address", want.phys_addr, got.phys_addr);
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("unmapped", 32'(want.unmapped), 32'(got.unmapped));
          check_field("hit_total", want.hit_total, got.hit_total);
          check_field("miss_total", want.miss_total, got.miss_total);
        end
      end
      // Input beat: predict its result.
      if (in_tvalid && in_tready)
        expected_xlat.insert(expected_xlat.size(),
                             translate_beat(in_tuser, in_tdata[9:0], in_tdata[29:10],
                                            in_tdata[61:30]));
      // Register access: track writes, check reads.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == tlbt_pkg::REG_PAGE_OFFSET)
            offset_bits = cfg_pwdata[tlbt_pkg::OFF_W-1:0];
          else entries_in_use = cfg_pwdata[tlbt_pkg::ENT_W-1:0];
        end else if (cfg_paddr[2] == tlbt_pkg::REG_PAGE_OFFSET) begin
          check_field("page_offset_bits readback", 32'(offset_bits), cfg_prdata);
        end else begin
          check_field("tlb_entries_in_use readback", 32'(entries_in_use), cfg_prdata);
        end
      end
      outstanding <= expected_xlat.size();
    end
  end

endmodule

// File: verif/tlbt_tb.sv
// Top of the TLB translate testbench: clock, reset, stimulus and the final verdict.
// Depends on tlbt_pkg, the tlb_lru_translate RTL and tlbt_xlat_checker.
module tlb_lru_translate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [9:0] page_number, [29:10] frame_number,
                                   // [61:30] virtual_address, [63:62] zero
  logic        in_tuser    = 1'b0; // [0] mode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;          // [31:0] physical_address, [63:32] hit_total,
                                   // [95:64] miss_total
  logic [1:0]  out_tuser;          // [0] hit, [1] unmapped
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned mismatches;
  int unsigned results_owed;

  // Stimulus knobs.
  logic [4:0]  cur_off      = tlbt_pkg::PAGE_OFFSET_RST;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  int          out_stall_left = 0;
  logic [9:0]  hot_page [24];
  int          hot_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tlb_lru_translate i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  tlbt_xlat_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .mismatches, .outstanding(results_owed)
  );

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Result side back-pressure, with calm stretches of steady ready.
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_tready     <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) out_stall_left <= 1 + pick_gap();
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 255) == 0) out_calm <= ($urandom_range(0, 2) == 0);
  end

  // Present one beat, holding tvalid high from a previous beat when no gap is wanted.
  task automatic send_beat(input logic mode, input logic [9:0] pg, input logic [19:0] fr,
                           input logic [31:0] va);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, va, fr, pg};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_mapping(input logic [9:0] pg, input logic [19:0] fr);
    send_beat(tlbt_pkg::MODE_LOAD, pg, fr, $urandom);
  endtask

  task automatic translate_addr(input logic [31:0] va);
    send_beat(tlbt_pkg::MODE_ACCESS, 10'($urandom), 20'($urandom), va);
  endtask

  // Address inside the given page at the current offset width, random offset.
  function automatic logic [31:0] addr_in_page(input logic [31:0] pg);
    logic [63:0] mask;
    mask = (64'd1 << cur_off) - 64'd1;
    return 32'(({32'd0, pg} << cur_off) | (64'($urandom) & mask));
  endfunction

  // Stop sending and wait until every result has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, with junk in the unused upper bits now and then, then read it back.
  task automatic program_reg(input logic idx, input logic [4:0] val);
    logic [26:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'd0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {junk, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == tlbt_pkg::REG_PAGE_OFFSET) cur_off = val;
  endtask

  initial begin
    int          fixed_off [6];
    int          fixed_cap [6];
    logic [4:0]  off_val;
    logic [4:0]  cap_val;
    int          r;
    fixed_off = '{12, 12, 0, 31, 4, 20};
    fixed_cap = '{16, 2, 1, 16, 0, 31};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings (12-bit offset, 16 entries).
    translate_addr(32'h0000_0000);        // empty table: unmapped miss
    load_mapping(10'd0, 20'hFFFFF);
    load_mapping(10'd1023, 20'h12345);
    load_mapping(10'd3, 20'h00000);
    translate_addr(32'h0000_0FFF);        // page 0 cached as unmapped: hit, frame 0
    translate_addr(32'h003F_FABC);        // last table page: mapped miss
    translate_addr(32'h003F_F001);        // same page: hit
    translate_addr(32'hFFFF_FFFF);        // far beyond the table
    translate_addr(32'h0040_0000);        // first page beyond the table
    load_mapping(10'd1023, 20'h00001);    // remap: the cached translation stays
    translate_addr(32'h003F_F000);
    load_mapping(10'd5, 20'hABCDE);
    translate_addr(32'h0000_5123);
    load_mapping(10'd2, 20'h80000);
    translate_addr(32'h0000_2FFF);
    translate_addr(32'h0000_3000);        // mapped to frame zero
    load_mapping(10'd1022, 20'h7FFFF);
    translate_addr(32'h003F_E800);
    translate_addr(32'h0000_0000);

    // Random phases, each at its own register settings.
    for (int phase = 0; phase < 13; phase++) begin
      wait_idle();
      if (phase < 6) begin
        off_val = 5'(fixed_off[phase]);
        cap_val = 5'(fixed_cap[phase]);
      end else begin
        off_val = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 16)) : 5'($urandom);
        cap_val = 5'($urandom);
      end
      program_reg(tlbt_pkg::REG_PAGE_OFFSET, off_val);
      program_reg(tlbt_pkg::REG_TLB_ENTRIES, cap_val);
      in_calm   = ($urandom_range(0, 3) == 0);
      // The first phase uses a working set large enough to fill and evict.
      hot_count = (phase == 0) ? 24 : $urandom_range(2, 24);
      for (int k = 0; k < 24; k++) hot_page[k] = 10'($urandom);
      for (int k = 0; k < hot_count; k++) begin
        if ($urandom_range(0, 4) != 0) load_mapping(hot_page[k], 20'($urandom));
      end

      for (int n = 0; n < 110; n++) begin
        r = $urandom_range(0, 99);
        if (r < 12)
          load_mapping(hot_page[$urandom_range(0, hot_count - 1)], 20'($urandom));
        else if (r < 20)
          load_mapping(10'($urandom), 20'($urandom));
        else if (r < 80)
          translate_addr(addr_in_page(32'(hot_page[$urandom_range(0, hot_count - 1)])));
        else if (r < 93)
          translate_addr(addr_in_page(32'($urandom_range(0, 1023))));
        else
          translate_addr($urandom);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
